// ===== rtl/core/msas_pkg.sv =====
// Package for the min stack: shared codes, defaults and the result record.
// No dependencies; imported by msas_ctrl and min_stack_aux_stack.
package msas_pkg;

  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned VW_DEF    = 32;

  // Fixed field widths of the stream words
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned OCC_W   = 9;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_UNF = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // One result word, top_value in the lowest bits
  typedef struct packed {
    status_t                    status;
    logic [OCC_W-1:0]           occupancy;
    logic                       is_empty;
    logic signed [FIELD_W-1:0]  min_value;
    logic signed [FIELD_W-1:0]  top_value;
  } res_t;

endpackage

// ===== rtl/core/msas_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on nothing; used for both the value and the minimum stacks.
module msas_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/msas_ctrl.sv =====
// Stack controller: counts, cached tops, both stack RAMs and the op sequencer.
// Depends on msas_pkg and msas_ram.
module msas_ctrl
  import msas_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       op_valid,
  output logic                       op_ready,
  input  opcode_t                    opcode,
  input  logic signed [FIELD_W-1:0]  push_value,
  output logic                       res_valid,
  input  logic                       res_ready,
  output res_t                       res
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           vcnt_r, vcnt_nxt, mcnt_r, mcnt_nxt;
  logic signed [VALUE_WIDTH-1:0] top_r, top_nxt, min_r, min_nxt;
  opcode_t                 op_r;
  status_t                 status_r, status_nxt;
  logic [AW-1:0]           vaddr_r, maddr_r;
  logic [CW-1:0]           vaddr_c, maddr_c;

  logic signed [VALUE_WIDTH-1:0] v;
  logic                    accept, full, empty, take, mdec, pop_ok;
  logic                    vwe, mwe;
  logic [AW-1:0]           vraddr, mraddr;
  logic [VALUE_WIDTH-1:0]  vrdata, mrdata;
  logic signed [VALUE_WIDTH-1:0] top_fin, min_fin;

  assign v      = VALUE_WIDTH'(push_value);
  assign accept = op_valid && (state_r == S_IDLE);
  assign full   = (vcnt_r == CW'(STACK_DEPTH));
  assign empty  = (vcnt_r == '0);
  assign take   = (mcnt_r == '0) || (v <= min_r);
  assign mdec   = (mcnt_r != '0) && (min_r == top_r);

  assign vwe    = accept && (opcode == OP_PUSH) && !full;
  assign mwe    = vwe && take && (mcnt_r != CW'(STACK_DEPTH));

  // Read addresses of the new tops after a pop
  assign vaddr_c = vcnt_r - CW'(2);
  assign maddr_c = mcnt_r - CW'(mdec) - CW'(1);
  assign vraddr  = (state_r == S_IDLE) ? vaddr_c[AW-1:0] : vaddr_r;
  assign mraddr  = (state_r == S_IDLE) ? maddr_c[AW-1:0] : maddr_r;

  msas_ram #(.DEPTH(STACK_DEPTH), .WIDTH(VALUE_WIDTH)) u_vram (
    .clk  (clk),
    .we   (vwe),
    .waddr(vcnt_r[AW-1:0]),
    .wdata(v),
    .raddr(vraddr),
    .rdata(vrdata)
  );

  msas_ram #(.DEPTH(STACK_DEPTH), .WIDTH(VALUE_WIDTH)) u_mram (
    .clk  (clk),
    .we   (mwe),
    .waddr(mcnt_r[AW-1:0]),
    .wdata(v),
    .raddr(mraddr),
    .rdata(mrdata)
  );

  // RAM data is live while in S_EXEC: address is held, no writes occur
  assign pop_ok  = (op_r == OP_POP) && (status_r == ST_OK);
  assign top_fin = pop_ok ? signed'(vrdata) : top_r;
  assign min_fin = pop_ok ? signed'(mrdata) : min_r;

  assign op_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_EXEC);

  always_comb begin
    res.top_value = empty ? '0 : FIELD_W'(top_fin);
    res.min_value = (mcnt_r == '0) ? '0 : FIELD_W'(min_fin);
    res.is_empty  = empty;
    res.occupancy = OCC_W'(vcnt_r);
    res.status    = status_r;
  end

  always_comb begin
    state_nxt  = state_r;
    vcnt_nxt   = vcnt_r;
    mcnt_nxt   = mcnt_r;
    top_nxt    = top_r;
    min_nxt    = min_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt  = S_EXEC;
          status_nxt = ST_OK;
          unique case (opcode)
            OP_PUSH: begin
              if (full) begin
                status_nxt = ST_OVF;
              end else begin
                vcnt_nxt = vcnt_r + CW'(1);
                top_nxt  = v;
                if (mwe) begin
                  mcnt_nxt = mcnt_r + CW'(1);
                  min_nxt  = v;
                end
              end
            end
            OP_POP: begin
              if (empty) begin
                status_nxt = ST_UNF;
              end else begin
                vcnt_nxt = vcnt_r - CW'(1);
                mcnt_nxt = mcnt_r - CW'(mdec);
              end
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
          top_nxt   = top_fin;
          min_nxt   = min_fin;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vcnt_r   <= '0;
      mcnt_r   <= '0;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      vcnt_r   <= vcnt_nxt;
      mcnt_r   <= mcnt_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    min_r <= min_nxt;
    if (accept) begin
      op_r    <= opcode;
      vaddr_r <= vaddr_c[AW-1:0];
      maddr_r <= maddr_c[AW-1:0];
    end
  end

endmodule

// ===== rtl/core/min_stack_aux_stack.sv =====
// Min stack top level: stream ports, output register, assertions.
// Depends on msas_pkg and msas_ctrl (which holds the two stack RAMs).
//
// Usage:
//   Input words carry one operation: in_tuser = opcode (push / pop),
//   in_tdata = push_value. Each accepted word yields exactly one output word
//   describing the stack after the operation: top, minimum, empty flag,
//   occupancy and status (ok, overflow-refused, underflow-refused).
//   An accepted word puts the controller in S_EXEC; out_tvalid rises once the
//   result is registered. in_tready stays low until the controller leaves S_EXEC. A
//   pop fetches the next-lower value and minimum RAM entries (synchronous read);
//   pushes use the cached tops but go through the same two-step sequence.
//   The output register holds the last result, so a new input word is taken
//   while a result still waits; if out_tready stays low the controller holds
//   its next result (RAM read address is held) and in_tready stays low until
//   the register drains.
//   Reset (rst_n low, synchronous) empties both stacks and drops out_tvalid;
//   RAM contents are not cleared, no clearing pass is needed.
module min_stack_aux_stack
  import msas_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [31:0] top_value, [63:32] min_value,
                                  // [64] is_empty, [73:65] occupancy,
                                  // [75:74] status, [79:76] zero
);

  localparam int unsigned RES_W = $bits(res_t);

  logic res_valid, res_ready;
  res_t res, res_r;
  logic out_valid_r;

  // Output slot is free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  msas_ctrl #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (in_tvalid),
    .op_ready  (in_tready),
    .opcode    (opcode_t'(in_tuser[0])),
    .push_value(signed'(in_tdata)),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(80 - RES_W)'(0), res_r};

`ifndef SYNTHESIS
  // Empty flag agrees with the occupancy
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[64] == (out_tdata[73:65] == '0)))
    else $error("is_empty does not match occupancy");

  // Refused pop only happens on an empty stack
  a_unf_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[75:74] == ST_UNF) |-> out_tdata[64])
    else $error("underflow reported on non-empty stack");

  // Refused push only happens on a full stack
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[75:74] == ST_OVF) |->
      (out_tdata[73:65] == OCC_W'(STACK_DEPTH)))
    else $error("overflow reported on non-full stack");

  // Each operation passes through S_EXEC: no back-to-back accept
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted in consecutive cycles");
`endif

endmodule
